// ----- sv/exp2sp_pkg.sv -----
`timescale 1ns / 1ps
package exp2sp_pkg;

  typedef struct packed {
    logic signed [9:0] e;
    logic [23:0]       m;
  } fpv_t;

  typedef struct packed {
    logic              s;
    logic signed [9:0] e;
    logic [23:0]       m;
  } rv_t;

  typedef struct packed {
    logic              spec;
    logic [31:0]       spec_y;
    logic signed [8:0] n;
  } side_t;

  localparam int NumFma = 6;
  localparam int FmaG = 5;
  localparam int FmaW = 30;

  localparam logic [31:0] QUIET_BIT = 32'h0040_0000;
  localparam logic [31:0] INF_BITS = 32'h7f80_0000;
  localparam logic [31:0] ZERO_BITS = 32'h0000_0000;

  localparam fpv_t COEF [0:NumFma] = '{
    '{e: -10'sd13, m: 24'hA0B5AF},
    '{e: -10'sd10, m: 24'hAF8417},
    '{e: -10'sd7,  m: 24'h9D96F0},
    '{e: -10'sd5,  m: 24'hE357BE},
    '{e: -10'sd3,  m: 24'hF5FDEE},
    '{e: -10'sd1,  m: 24'hB17218},
    '{e: 10'sd0,   m: 24'h800000}
  };

  function automatic logic [4:0] lzc24(input logic [23:0] v);
    logic [4:0] cnt;
    logic       found;
    cnt = 5'd0;
    found = 1'b0;
    for (int i = 23; i >= 0; i--) begin
      if (!found) begin
        if (v[i]) begin
          found = 1'b1;
        end else begin
          cnt = cnt + 5'd1;
        end
      end
    end
    return cnt;
  endfunction

endpackage

// ----- sv/exp2sp_fma.sv -----
`timescale 1ns / 1ps
module exp2sp_fma import exp2sp_pkg::*; (
  input  logic clk,
  input  logic en,
  input  fpv_t a,
  input  fpv_t c,
  input  rv_t  r,
  output fpv_t y,
  output rv_t  r_out
);

  logic [47:0]        prod;
  logic signed [10:0] pexp;
  logic               psign;
  fpv_t               c_mid;
  rv_t                r_mid;

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= a.m * r.m;
      pexp <= 11'(a.e) + 11'(r.e);
      psign <= r.s;
      c_mid <= c;
      r_mid <= r;
    end
  end

  logic signed [11:0] rsh;
  logic [47:0]        phi_w;
  logic               st;
  logic [FmaW-1:0]    phi;
  logic [FmaW-1:0]    cw;
  logic [FmaW-1:0]    sum;
  logic [23:0]        mant;
  logic               guard;
  logic               sticky;
  logic               up;
  logic signed [9:0]  ebase;
  logic [24:0]        m25;
  fpv_t               y_next;

  always_comb begin
    rsh = 12'(c_mid.e) + 12'(23 - FmaG) - 12'(pexp);
    if (rsh > 12'sd47) begin
      phi_w = '0;
      st = |prod;
    end else if (rsh < 12'sd0) begin
      phi_w = prod;
      st = 1'b0;
    end else begin
      phi_w = prod >> rsh[5:0];
      st = (phi_w << rsh[5:0]) != prod;
    end
    phi = phi_w[FmaW-1:0];
    cw = {1'b0, c_mid.m, FmaG'(0)};
    if (psign) begin
      sum = cw - phi - FmaW'(st);
    end else begin
      sum = cw + phi;
    end
    sum[0] = sum[0] | st;
    if (sum[29]) begin
      mant = sum[29:6];
      guard = sum[5];
      sticky = |sum[4:0];
      ebase = c_mid.e + 10'sd1;
    end else if (sum[28]) begin
      mant = sum[28:5];
      guard = sum[4];
      sticky = |sum[3:0];
      ebase = c_mid.e;
    end else begin
      mant = sum[27:4];
      guard = sum[3];
      sticky = |sum[2:0];
      ebase = c_mid.e - 10'sd1;
    end
    up = guard & (sticky | mant[0]);
    m25 = {1'b0, mant} + 25'(up);
    if (m25[24]) begin
      y_next.m = m25[24:1];
      y_next.e = ebase + 10'sd1;
    end else begin
      y_next.m = m25[23:0];
      y_next.e = ebase;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y <= y_next;
      r_out <= r_mid;
    end
  end

endmodule

// ----- sv/exp2_single_precision.sv -----
`timescale 1ns / 1ps
// Computes 2^x for one IEEE-754 single-precision argument per transaction.
// The input channel is x_bits with x_valid and x_ready; the output channel
// is y_bits with y_valid and y_ready. A transaction happens on a rising edge
// where valid and ready are both high.
// The pipeline has 16 register stages. When the output is not stalled, one
// argument is accepted every cycle; the throughput is one result per cycle.
// The stages are argument decode, integer split, reduced argument
// normalization, six fused multiply-adds of two stages each, and the final
// scaling with subnormal rounding.
// Reset empties the pipeline; no results are pending afterwards.
// When the receiver holds y_ready low with a result waiting, the whole
// pipeline freezes and x_ready drops, so nothing is lost or repeated.
// NaN arguments return the quieted NaN, large arguments give infinity or zero.
module exp2_single_precision import exp2sp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] x_bits,
  input  logic        x_valid,
  output logic        x_ready,
  output logic [31:0] y_bits,
  output logic        y_valid,
  input  logic        y_ready
);

  localparam int Depth = 4 + 2 * NumFma;

  logic             en;
  logic [Depth-1:0] vld;

  assign en = !vld[Depth-1] || y_ready;
  assign x_ready = en;
  assign y_valid = vld[Depth-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Depth-2:0], x_valid};
    end
  end

  logic [7:0]  xe;
  logic [22:0] xf;
  logic [3:0]  shamt;
  logic [31:0] s1_x;
  logic        s1_nan;
  logic        s1_big;
  logic        s1_small;
  logic [31:0] s1_fix;

  assign xe = x_bits[30:23];
  assign xf = x_bits[22:0];
  assign shamt = 4'(xe - 8'd126);

  always_ff @(posedge clk) begin
    if (en) begin
      s1_x <= x_bits;
      s1_nan <= (xe == 8'hff) && (xf != 23'd0);
      s1_big <= xe >= 8'd135;
      s1_small <= xe < 8'd126;
      s1_fix <= {8'd0, xe != 8'd0, xf} << shamt;
    end
  end

  logic [8:0]  nabs;
  logic        huge;
  logic [23:0] mag;
  side_t       side2_next;
  side_t       s2_side;
  logic        s2_small;
  logic [31:0] s2_x;
  logic        s2_rs;
  logic [23:0] s2_mag;

  always_comb begin
    nabs = {1'b0, s1_fix[31:24]} + 9'(s1_fix[23]);
    if (s1_fix[23]) begin
      mag = 24'(25'h100_0000 - {1'b0, s1_fix[23:0]});
    end else begin
      mag = s1_fix[23:0];
    end
    huge = s1_big || (!s1_small && (nabs > 9'd192));
    side2_next.spec = s1_nan || huge;
    if (s1_nan) begin
      side2_next.spec_y = s1_x | QUIET_BIT;
    end else if (s1_x[31]) begin
      side2_next.spec_y = ZERO_BITS;
    end else begin
      side2_next.spec_y = INF_BITS;
    end
    if (s1_small) begin
      side2_next.n = '0;
    end else if (s1_x[31]) begin
      side2_next.n = 9'(-nabs);
    end else begin
      side2_next.n = nabs;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_side <= side2_next;
      s2_small <= s1_small;
      s2_x <= s1_x;
      s2_rs <= s1_x[31] ^ s1_fix[23];
      s2_mag <= mag;
    end
  end

  logic [4:0] lz;
  rv_t        r_next;
  rv_t        st3_r;
  side_t      st3_side;

  always_comb begin
    lz = lzc24(s2_mag);
    if (s2_small) begin
      r_next.s = s2_x[31];
      r_next.m = {s2_x[30:23] != 8'd0, s2_x[22:0]};
      if (s2_x[30:23] == 8'd0) begin
        r_next.e = -10'sd126;
      end else begin
        r_next.e = 10'({2'b00, s2_x[30:23]}) - 10'sd127;
      end
    end else begin
      r_next.s = s2_rs;
      r_next.m = s2_mag << lz;
      r_next.e = -10'sd1 - 10'(lz);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st3_r <= r_next;
      st3_side <= s2_side;
    end
  end

  fpv_t  poly [0:NumFma-1];
  rv_t   rr [0:NumFma-1];
  side_t sd [0:2*NumFma-1];

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= st3_side;
      for (int i = 1; i < 2 * NumFma; i++) begin
        sd[i] <= sd[i-1];
      end
    end
  end

  for (genvar k = 0; k < NumFma; k++) begin : g_fma
    if (k == 0) begin : g_first
      exp2sp_fma u_fma (
        .clk   (clk),
        .en    (en),
        .a     (COEF[0]),
        .c     (COEF[1]),
        .r     (st3_r),
        .y     (poly[0]),
        .r_out (rr[0])
      );
    end else begin : g_next
      exp2sp_fma u_fma (
        .clk   (clk),
        .en    (en),
        .a     (poly[k-1]),
        .c     (COEF[k+1]),
        .r     (rr[k-1]),
        .y     (poly[k]),
        .r_out (rr[k])
      );
    end
  end

  fpv_t               p;
  side_t              sf;
  logic signed [10:0] ex;
  logic signed [10:0] sh;
  logic [48:0]        ext;
  logic               rup;
  logic [30:0]        qr;
  logic [31:0]        y_next;

  always_comb begin
    p = poly[NumFma-1];
    sf = sd[2*NumFma-1];
    ex = 11'(p.e) + 11'sd127 + 11'(sf.n);
    sh = 11'sd1 - ex;
    ext = {p.m, 25'd0} >> sh[4:0];
    rup = ext[24] & ((|ext[23:0]) | ext[25]);
    qr = 31'(ext[48:25]) + 31'(rup);
    if (sf.spec) begin
      y_next = sf.spec_y;
    end else if (ex >= 11'sd255) begin
      y_next = INF_BITS;
    end else if (ex >= 11'sd1) begin
      y_next = {1'b0, ex[7:0], p.m[22:0]};
    end else if (sh > 11'sd25) begin
      y_next = ZERO_BITS;
    end else begin
      y_next = {1'b0, qr};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y_bits <= y_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    vld[1] && !s2_side.spec |-> (s2_side.n >= -9'sd192) && (s2_side.n <= 9'sd192))
    else $error("integer part out of range on the normal path");

  assert property (@(posedge clk) disable iff (rst)
    vld[2] && (st3_r.m != 24'd0)
      |-> (st3_r.m[23] || (st3_r.e == -10'sd126)) && (st3_r.e <= -10'sd1))
    else $error("reduced argument is not normalized or exceeds one half");

  assert property (@(posedge clk) disable iff (rst)
    vld[Depth-2] |-> poly[NumFma-1].m[23]
      && ((poly[NumFma-1].e == -10'sd1) || (poly[NumFma-1].e == 10'sd0)))
    else $error("polynomial result outside its expected binade");

  assert property (@(posedge clk) disable iff (rst)
    y_valid && (y_bits[30:23] == 8'hff) && (y_bits[22:0] != 23'd0) |-> y_bits[22])
    else $error("NaN result is not quiet");

endmodule

// ----- test/tb_exp2_single_precision.sv -----
`timescale 1ns / 1ps
module tb_exp2_single_precision;
  import exp2sp_pkg::*;

  localparam logic [31:0] NEG_SPLIT = 32'h8300_0000;
  localparam logic [31:0] S1_BASE = 32'h7f00_0000;
  localparam logic [31:0] ONE_BITS = 32'h3f80_0000;
  localparam logic [31:0] C0_BITS = 32'h3920_b5af;
  localparam logic [31:0] C1_BITS = 32'h3aaf_8417;
  localparam logic [31:0] C2_BITS = 32'h3c1d_96f0;
  localparam logic [31:0] C3_BITS = 32'h3d63_57be;
  localparam logic [31:0] C4_BITS = 32'h3e75_fdee;
  localparam logic [31:0] C5_BITS = 32'h3f31_7218;
  localparam int IDLE_LIMIT = 5000;
  localparam int RANDOM_ITEMS = 720;

  logic        clk;
  logic        rst;
  logic [31:0] x_bits;
  logic        x_valid;
  logic        x_ready;
  logic [31:0] y_bits;
  logic        y_valid;
  logic        y_ready;

  logic [31:0] expected_y[$];
  int          mismatches = 0;
  int          idle_cycles = 0;

  exp2_single_precision uut (
    .clk(clk),
    .rst(rst),
    .x_bits(x_bits),
    .x_valid(x_valid),
    .x_ready(x_ready),
    .y_bits(y_bits),
    .y_valid(y_valid),
    .y_ready(y_ready)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic logic [31:0] to_single(real d);
    logic [63:0] b;
    logic [63:0] m;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    logic [63:0] res;
    int          ef;
    int          sh;
    b = $realtobits(d);
    if (b[62:52] == 11'h7ff) begin
      if (b[51:0] != 0) begin
        return {b[63], 8'hff, 1'b1, b[50:29]};
      end
      return {b[63], 8'hff, 23'h0};
    end
    if (b[62:52] == 11'h0) begin
      return {b[63], 31'h0};
    end
    ef = int'(b[62:52]) - 1023 + 127;
    if (ef >= 255) begin
      return {b[63], 8'hff, 23'h0};
    end
    m = {11'h0, 1'b1, b[51:0]};
    sh = (ef >= 1) ? 29 : 29 + 1 - ef;
    if (sh >= 60) begin
      return {b[63], 31'h0};
    end
    q = m >> sh;
    rem = m & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) begin
      q = q + 64'd1;
    end
    res = (ef >= 1) ? ((64'(ef - 1) << 23) + q) : q;
    if (res >= 64'h7f80_0000) begin
      res = 64'h7f80_0000;
    end
    return {b[63], res[30:0]};
  endfunction

  function automatic real to_double(logic [31:0] f);
    real d;
    if (f[30:23] == 8'hff) begin
      return $bitstoreal({f[31], 11'h7ff, f[22:0], 29'h0});
    end
    if (f[30:23] == 8'h0) begin
      d = real'(f[22:0]) * $bitstoreal({1'b0, 11'(1023 - 149), 52'h0});
      return f[31] ? -d : d;
    end
    return $bitstoreal({f[31], 11'(int'(f[30:23]) - 127 + 1023), f[22:0], 29'h0});
  endfunction

  function automatic logic [31:0] fused_mul_add(logic [31:0] a, real bd, logic [31:0] c);
    real         p;
    real         cd;
    real         s;
    real         bv;
    real         err;
    logic [63:0] sb;
    p = to_double(a) * bd;
    cd = to_double(c);
    s = p + cd;
    if (s != s || (s - s) != 0.0) begin
      return to_single(s);
    end
    bv = s - p;
    err = (p - (s - bv)) + (cd - bv);
    if (err != 0.0) begin
      sb = $realtobits(s);
      if (!sb[0]) begin
        if ((err > 0.0) == (s > 0.0)) begin
          sb = sb + 64'd1;
        end else begin
          sb = sb - 64'd1;
        end
      end
      s = $bitstoreal(sb);
    end
    return to_single(s);
  endfunction

  function automatic logic [31:0] pow2_of(logic [31:0] xb);
    real         x;
    real         a;
    real         f;
    real         n;
    real         absn;
    real         r;
    real         s1;
    logic [31:0] b;
    logic [31:0] poly;
    logic [31:0] e;
    logic [31:0] t;
    if (xb[30:23] == 8'hff && xb[22:0] != 0) begin
      return xb | QUIET_BIT;
    end
    x = to_double(xb);
    a = x < 0.0 ? -x : x;
    if (!(a < 8388608.0)) begin
      n = x;
    end else begin
      f = real'($rtoi(a));
      if (a - f >= 0.5) begin
        f = f + 1.0;
      end
      n = xb[31] ? -f : f;
    end
    absn = n < 0.0 ? -n : n;
    b = (n <= 0.0) ? NEG_SPLIT : 32'h0;
    s1 = to_double(S1_BASE + b);
    if (absn > 192.0) begin
      return to_single(s1 * s1);
    end
    r = to_double(to_single(x - n));
    poly = fused_mul_add(C0_BITS, r, C1_BITS);
    poly = fused_mul_add(poly, r, C2_BITS);
    poly = fused_mul_add(poly, r, C3_BITS);
    poly = fused_mul_add(poly, r, C4_BITS);
    poly = fused_mul_add(poly, r, C5_BITS);
    poly = fused_mul_add(poly, r, ONE_BITS);
    e = 32'($rtoi(n)) << 23;
    if (absn > 126.0) begin
      t = to_single(to_double(poly) * s1);
      return to_single(to_double(t) * to_double(e - b));
    end
    return to_single(to_double(e + ONE_BITS) * to_double(poly));
  endfunction

  task automatic send_arg(logic [31:0] xb);
    int   gap;
    logic ok;
    gap = $urandom_range(0, 19);
    if ($urandom_range(0, 3) == 0) begin
      gap = 0;
    end
    if (gap > 0) begin
      x_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    x_bits <= xb;
    x_valid <= 1'b1;
    do begin
      @(negedge clk);
      ok = x_ready;
      @(posedge clk);
    end while (!ok);
    expected_y.push_back(pow2_of(xb));
  endtask

  function automatic logic [31:0] random_arg();
    real v;
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: begin
        v = real'($urandom()) / 4294967296.0 * 400.0 - 200.0;
        return to_single(v);
      end
      2: begin
        v = real'($urandom()) / 4294967296.0 * 8.0 - 4.0;
        return to_single(v);
      end
      3: return to_single(real'($urandom_range(0, 400)) - 200.0 + 0.5)
             + 32'($urandom_range(0, 2)) - 32'd1;
      4: return {1'($urandom()), 8'($urandom_range(0, 20)), 23'($urandom())};
      default: return to_single(real'($urandom()) / 4294967296.0 * 80.0
                                + ($urandom_range(0, 1) ? 115.0 : -195.0));
    endcase
  endfunction

  task automatic test_special_values();
    logic [31:0] vals[$];
    vals = '{32'h0000_0000, 32'h8000_0000, 32'h7f80_0000, 32'hff80_0000,
             32'h7fc0_0000, 32'h7f80_0001, 32'hffa5_5a5a, 32'h7fff_ffff,
             32'h3f80_0000, 32'h3f00_0000, 32'hbf00_0000, 32'h42ff_0000,
             32'h4300_0000, 32'hc2fd_0000, 32'hc315_0000, 32'hc316_0000,
             32'h4340_8000, 32'h4340_7fff, 32'hc340_8000, 32'h7f7f_ffff,
             32'hff7f_ffff, 32'h0000_0001, 32'h8000_0001, 32'h3eff_ffff,
             32'h007f_ffff};
    foreach (vals[i]) begin
      send_arg(vals[i]);
    end
  endtask

  task automatic test_random_args(int count);
    repeat (count) begin
      send_arg(random_arg());
    end
  endtask

  task automatic test_drain_then_burst();
    x_valid <= 1'b0;
    @(posedge clk);
    while (expected_y.size() != 0) begin
      @(posedge clk);
    end
    test_random_args(20);
  endtask

  initial begin
    logic ok;
    int   wait_cycles;
    y_ready = 1'b0;
    @(negedge rst);
    forever begin
      wait_cycles = 0;
      if ($urandom_range(0, 1) == 0) begin
        wait_cycles = $urandom_range(0, 19);
      end
      if (wait_cycles > 0) begin
        y_ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      y_ready <= 1'b1;
      do begin
        @(negedge clk);
        ok = y_valid;
        if (ok) begin
          if (expected_y.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("Unexpected transaction: y_bits=%h", y_bits);
            end
          end else if (expected_y[0] !== y_bits) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("Mismatch: expected %h, actual %h", expected_y[0], y_bits);
            end
            void'(expected_y.pop_front());
          end else begin
            void'(expected_y.pop_front());
          end
        end
        @(posedge clk);
      end while (!ok);
    end
  end

  always @(negedge clk) begin
    if (rst || (x_valid && x_ready) || (y_valid && y_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    x_valid = 1'b0;
    x_bits = 32'h0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_special_values();
    test_random_args(RANDOM_ITEMS / 2);
    test_drain_then_burst();
    test_random_args(RANDOM_ITEMS / 2);
    x_valid <= 1'b0;
    while (expected_y.size() != 0) begin
      @(posedge clk);
    end
    repeat (40) @(posedge clk);
    if (mismatches == 0 && expected_y.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- exp2_single_precision.f -----
sv/exp2sp_pkg.sv
sv/exp2sp_fma.sv
sv/exp2_single_precision.sv
test/tb_exp2_single_precision.sv
